@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 64;
   localparam int MODE_W  = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

   // operation applied to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_MATCH,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctrl_type             ctrl,
   input  logic                      occupied,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [PRIO_W-1:0]  left_prio,
   input  logic                      left_pos,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic signed [PRIO_W-1:0]  right_prio,
   input  logic                      right_match,
   output logic signed [VALUE_W-1:0] value,
   output logic signed [PRIO_W-1:0]  prio,
   output logic                      pos,
   output logic                      match
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [PRIO_W-1:0]  prio_ff, prio_in;
   logic                      match_ff, match_in;

   // new entry belongs at or before this cell
   assign pos = !occupied || (ctrl.prio < prio_ff);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      match_in = match_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_pos) begin
               value_in = left_value;
               prio_in  = left_prio;
            end else if (pos) begin
               value_in = ctrl.value;
               prio_in  = ctrl.prio;
            end
         end
         CELL_REMOVE: begin
            value_in = right_value;
            prio_in  = right_prio;
         end
         CELL_MATCH: match_in = occupied && (value_ff == ctrl.value);
         CELL_SHIFT: match_in = right_match;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign prio  = prio_ff;
   assign match = match_ff;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// sorted priority queue, smallest priority leaves first, stable on ties
//
// req channel: valid/ready transfer of mode, item_value, item_priority
// rsp channel: valid/ready transfer of one result per request
// entries live in a row of cells kept in ascending priority order,
// cell 0 is the head; each cell compares the new priority locally and
// takes its own, the new or its left neighbor's entry on insert, and its
// right neighbor's entry on remove
// insert, remove and unused mode: result valid on the next cycle,
// one request per cycle while the result register drains
// find: match flags load into the cells, then shift toward the head one
// cell a cycle until the first match reaches the head cell or the scan
// passes the last entry; no request is taken meanwhile
// reset empties the queue and drops any pending result
// when the receiver stalls the result register holds, and a new request
// is taken only in the cycle the waiting result transfers

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic signed [PRIO_W-1:0]  req_item_priority,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_head_present,
   output logic signed [VALUE_W-1:0] rsp_head_value
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                 state_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             scan_idx_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_removed_ff;
   logic [POS_W-1:0]          rsp_position_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_present_ff;
   logic signed [VALUE_W-1:0] rsp_head_ff;

   cell_ctrl_type             ctrl;
   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      scan_done;
   logic                      scan_hit;
   logic signed [VALUE_W-1:0] head_now;

   logic signed [VALUE_W-1:0] cell_value [QUEUE_DEPTH];
   logic signed [PRIO_W-1:0]  cell_prio  [QUEUE_DEPTH];
   logic                      cell_pos   [QUEUE_DEPTH];
   logic                      cell_match [QUEUE_DEPTH];

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // head as it stands before this request
   assign head_now = empty ? '0 : cell_value[0];

   // output register must be free or transferring this cycle
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // scan finishes on the first flag at the head cell or past the last entry
   assign scan_hit  = (scan_idx_ff != count_ff) && cell_match[0];
   assign scan_done = (scan_idx_ff == count_ff) || cell_match[0];

   // row command
   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.value = req_item_value;
      ctrl.prio  = req_item_priority;
      if (state_ff == S_SCAN) begin
         if (!scan_done) begin
            ctrl.op = CELL_SHIFT;
         end
      end else if (accept) begin
         case (req_mode)
            MODE_INSERT: ctrl.op = full  ? CELL_HOLD : CELL_INSERT;
            MODE_REMOVE: ctrl.op = empty ? CELL_HOLD : CELL_REMOVE;
            MODE_FIND:   ctrl.op = CELL_MATCH;
            default:     ctrl.op = CELL_HOLD;
         endcase
      end
   end

   // row of cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lv;
      logic signed [PRIO_W-1:0]  lp;
      logic                      lpos;
      logic signed [VALUE_W-1:0] rv;
      logic signed [PRIO_W-1:0]  rp;
      logic                      rm;

      if (i == 0) begin : g_head
         assign lv   = '0;
         assign lp   = '0;
         assign lpos = 1'b0;
      end else begin : g_left
         assign lv   = cell_value[i-1];
         assign lp   = cell_prio[i-1];
         assign lpos = cell_pos[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign rv = '0;
         assign rp = '0;
         assign rm = 1'b0;
      end else begin : g_right
         assign rv = cell_value[i+1];
         assign rp = cell_prio[i+1];
         assign rm = cell_match[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .occupied    (count_ff > CW'(i)),
         .left_value  (lv),
         .left_prio   (lp),
         .left_pos    (lpos),
         .right_value (rv),
         .right_prio  (rp),
         .right_match (rm),
         .value       (cell_value[i]),
         .prio        (cell_prio[i]),
         .pos         (cell_pos[i]),
         .match       (cell_match[i])
      );
   end

   // control, entry count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a request taken in the same cycle reloads the result register itself
         if (rsp_valid_ff && rsp_ready && !accept) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_mode)
                     MODE_INSERT: begin
                        rsp_removed_ff  <= '0;
                        rsp_position_ff <= '0;
                        if (!full) begin
                           count_ff       <= count_ff + 1'b1;
                           rsp_status_ff  <= 1'b1;
                           rsp_count_ff   <= COUNT_W'(count_ff + 1'b1);
                           rsp_present_ff <= 1'b1;
                           rsp_head_ff    <= cell_pos[0] ? req_item_value : cell_value[0];
                        end else begin
                           rsp_status_ff  <= 1'b0;
                           rsp_count_ff   <= COUNT_W'(count_ff);
                           rsp_present_ff <= !empty;
                           rsp_head_ff    <= head_now;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     MODE_REMOVE: begin
                        rsp_position_ff <= '0;
                        if (!empty) begin
                           count_ff       <= count_ff - 1'b1;
                           rsp_status_ff  <= 1'b1;
                           rsp_removed_ff <= cell_value[0];
                           rsp_count_ff   <= COUNT_W'(count_ff - 1'b1);
                           rsp_present_ff <= (count_ff > CW'(1));
                           rsp_head_ff    <= (count_ff > CW'(1)) ? cell_value[1] : '0;
                        end else begin
                           rsp_status_ff  <= 1'b0;
                           rsp_removed_ff <= '0;
                           rsp_count_ff   <= COUNT_W'(count_ff);
                           rsp_present_ff <= 1'b0;
                           rsp_head_ff    <= '0;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     MODE_FIND: begin
                        // queue is unchanged by a find, status and position follow the scan
                        rsp_removed_ff <= '0;
                        rsp_count_ff   <= COUNT_W'(count_ff);
                        rsp_present_ff <= !empty;
                        rsp_head_ff    <= head_now;
                        rsp_valid_ff   <= 1'b0;
                        scan_idx_ff    <= '0;
                        state_ff       <= S_SCAN;
                     end
                     default: begin
                        rsp_status_ff   <= 1'b0;
                        rsp_removed_ff  <= '0;
                        rsp_position_ff <= '0;
                        rsp_count_ff    <= COUNT_W'(count_ff);
                        rsp_present_ff  <= !empty;
                        rsp_head_ff     <= head_now;
                        rsp_valid_ff    <= 1'b1;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= scan_hit;
                  rsp_position_ff <= scan_hit ? POS_W'(scan_idx_ff) : '0;
                  state_ff        <= S_IDLE;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_position_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_head_present   = rsp_present_ff;
   assign rsp_head_value     = rsp_head_ff;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import spq_pkg::*;

   localparam int                DEPTH        = DEFAULT_QUEUE_DEPTH;
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int                RANDOM_ITEMS = 1700;
   localparam int                IDLE_PCT     = 13;

   typedef struct packed {
      logic               status;
      logic [VALUE_W-1:0] removed_value;
      logic [POS_W-1:0]   found_position;
      logic [COUNT_W-1:0] entry_count;
      logic               head_present;
      logic [VALUE_W-1:0] head_value;
   } outcome_t;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
      int                 reps;
      bit                 typed;
      outcome_t           want;
   } stim_row_t;

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode           = MODE_INSERT;
   logic signed [VALUE_W-1:0] req_item_value     = '0;
   logic signed [PRIO_W-1:0]  req_item_priority  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready          = 1'b0;
   logic                      rsp_status;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [POS_W-1:0]          rsp_found_position;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic                      rsp_head_present;
   logic signed [VALUE_W-1:0] rsp_head_value;

   // shadow copy of the queue contents, head at index 0
   logic [VALUE_W-1:0]       held_value [DEPTH];
   logic signed [PRIO_W-1:0] held_prio [DEPTH];
   int                       held = 0;

   outcome_t  due_outcomes[$];
   stim_row_t stim_table[$];
   int        errors = 0;
   bit        calm   = 1'b0;

   sorted_priority_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_item_value     (req_item_value),
      .req_item_priority  (req_item_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_present   (rsp_head_present),
      .rsp_head_value     (rsp_head_value)
   );

   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // next result of the queue for one request; updates the shadow copy
   function automatic outcome_t apply_request(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
                                              logic signed [PRIO_W-1:0] p);
      outcome_t o;
      int       at;
      o = '0;
      case (m)
         MODE_INSERT: begin
            if (held < DEPTH) begin
               at = 0;
               // stable: go past every entry of equal or smaller priority
               while (at < held && !(p < held_prio[at])) at++;
               for (int i = held; i > at; i--) begin
                  held_value[i] = held_value[i-1];
                  held_prio[i]  = held_prio[i-1];
               end
               held_value[at] = v;
               held_prio[at]  = p;
               held++;
               o.status = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (held > 0) begin
               o.removed_value = held_value[0];
               for (int i = 1; i < held; i++) begin
                  held_value[i-1] = held_value[i];
                  held_prio[i-1]  = held_prio[i];
               end
               held--;
               o.status = 1'b1;
            end
         end
         MODE_FIND: begin
            for (int i = 0; i < held && !o.status; i++) begin
               if (held_value[i] == v) begin
                  o.status         = 1'b1;
                  o.found_position = i[POS_W-1:0];
               end
            end
         end
         default: ;
      endcase
      o.entry_count  = held[COUNT_W-1:0];
      o.head_present = held > 0;
      o.head_value   = held > 0 ? held_value[0] : '0;
      return o;
   endfunction

   function automatic void add_row(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
                                   logic [PRIO_W-1:0] p, int reps = 1, bit typed = 1'b0,
                                   outcome_t want = '0);
      stim_row_t r;
      r.mode  = m;
      r.value = v;
      r.prio  = p;
      r.reps  = reps;
      r.typed = typed;
      r.want  = want;
      stim_table.push_back(r);
   endfunction

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   // compare at the falling edge; the transfer itself happens at the next rising edge
   always @(negedge clock) begin
      outcome_t w;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
         end else begin
            w = due_outcomes.pop_front();
            check_field("status", 32'(w.status), 32'(rsp_status));
            check_field("removed_value", w.removed_value, rsp_removed_value);
            check_field("found_position", 32'(w.found_position), 32'(rsp_found_position));
            check_field("entry_count", 32'(w.entry_count), 32'(rsp_entry_count));
            check_field("head_present", 32'(w.head_present), 32'(rsp_head_present));
            check_field("head_value", w.head_value, rsp_head_value);
         end
      end
   end

   task automatic send_request(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
                               logic [PRIO_W-1:0] p, bit typed = 1'b0, outcome_t want = '0);
      outcome_t got;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_item_value    <= v;
      req_item_priority <= p;
      do @(negedge clock); while (!req_ready);
      // transfer takes place at the coming rising edge
      got = apply_request(m, v, p);
      due_outcomes.push_back(typed ? want : got);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_outcomes.size() != 0);
   endtask

   initial begin
      logic [MODE_W-1:0]  m;
      logic [VALUE_W-1:0] v;
      logic [PRIO_W-1:0]  p;
      int                 served;
      int                 pick;
      bit                 filling;

      // edge cases first: empty queue, extreme values, ties, full queue, drain
      add_row(MODE_REMOVE, '0, '0, 1, 1'b1, '{1'b0, 32'd0, 4'd0, 5'd0, 1'b0, 32'd0});
      add_row(MODE_FIND, '0, '0, 1, 1'b1, '{1'b0, 32'd0, 4'd0, 5'd0, 1'b0, 32'd0});
      add_row(MODE_IGNORED, '0, '0, 1, 1'b1, '{1'b0, 32'd0, 4'd0, 5'd0, 1'b0, 32'd0});
      add_row(MODE_INSERT, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 1, 1'b1,
              '{1'b1, 32'd0, 4'd0, 5'd1, 1'b1, 32'h7fff_ffff});
      add_row(MODE_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 1, 1'b1,
              '{1'b1, 32'd0, 4'd0, 5'd2, 1'b1, 32'h8000_0000});
      add_row(MODE_INSERT, 32'd0, 64'd0);
      add_row(MODE_INSERT, 32'd5, 64'd0);
      add_row(MODE_INSERT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
      add_row(MODE_FIND, 32'h7fff_ffff, '0);
      add_row(MODE_FIND, 32'd12345, '0);
      add_row(MODE_FIND, 32'd5, '0);
      add_row(MODE_IGNORED, 32'haaaa_aaaa, 64'h5555_5555_5555_5555);
      add_row(MODE_REMOVE, '0, '0);
      add_row(MODE_INSERT, 32'd100, 64'd10, 11);
      add_row(MODE_INSERT, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      add_row(MODE_INSERT, 32'd77, 64'd1, 1, 1'b1,
              '{1'b0, 32'd0, 4'd0, 5'd16, 1'b1, 32'h5555_5555});
      add_row(MODE_FIND, 32'h7fff_ffff, '0);
      add_row(MODE_REMOVE, '0, '0, 16);
      add_row(MODE_REMOVE, '0, '0, 1, 1'b1, '{1'b0, 32'd0, 4'd0, 5'd0, 1'b0, 32'd0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[r]) begin
         repeat (stim_table[r].reps) begin
            send_request(stim_table[r].mode, stim_table[r].value, stim_table[r].prio,
                         stim_table[r].typed, stim_table[r].want);
         end
      end

      served = 0;
      while (served < RANDOM_ITEMS) begin
         if (served % 400 == 399) wait_drained();
         calm    = served >= 700 && served < 1000;
         // alternate fill-heavy and drain-heavy stretches so full and empty both recur
         filling = (served / 50) % 2 == 0;
         pick    = $urandom_range(0, 99);
         v       = $urandom;
         p       = {$urandom, $urandom};
         if (pick < 3) begin
            m = MODE_IGNORED;
         end else if (pick < 23) begin
            m = MODE_FIND;
            if (held > 0 && $urandom_range(0, 99) < 70) v = held_value[$urandom_range(0, held-1)];
            else if ($urandom_range(0, 1) == 0) v = $urandom_range(0, 7);
         end else if (pick < (filling ? 80 : 45)) begin
            m = MODE_INSERT;
            if ($urandom_range(0, 99) < 60) v = $urandom_range(0, 7);
            // mostly a narrow band of priorities so ties are common
            if ($urandom_range(0, 99) < 70) p = 64'($urandom_range(0, 6)) - 64'd3;
         end else begin
            m = MODE_REMOVE;
         end
         send_request(m, v, p);
         if (m != MODE_IGNORED) served++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
test/tb.sv
